[rtl/tmsr_pkg.sv]
`default_nettype none

package tmsr_pkg;

	localparam int MODE_W     = 2;
	localparam int ROW_W      = 6;
	localparam int COL_W      = 7;
	localparam int CODE_W     = 8;
	localparam int GIDX_W     = 8;
	localparam int GROW_W     = 4;
	localparam int GBITS_W    = 16;
	localparam int LINE_W     = 10;
	localparam int WORD_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int PCNT_W     = 12;

	localparam logic [MODE_W-1:0] MODE_CELL   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GLYPH  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RENDER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CHAR_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAR_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHAR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_BITS   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_H_RES       = 3'd7;

	localparam logic [CODE_W-1:0] SPACE_CODE = 8'h20;
	localparam logic [PCNT_W-1:0] COUNT_CAP  = 12'd2048;

	typedef struct packed {
		logic [4:0]  char_width;
		logic [4:0]  char_height;
		logic [7:0]  first_char;
		logic [8:0]  glyph_count;
		logic [7:0]  fg_color;
		logic [7:0]  bg_color;
		logic [7:0]  sync_bits;
		logic [10:0] h_res;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0]  op;
		logic [ROW_W-1:0]   text_row;
		logic [COL_W-1:0]   text_col;
		logic [CODE_W-1:0]  char_code;
		logic [GIDX_W-1:0]  glyph_index;
		logic [GROW_W-1:0]  glyph_row;
		logic [GBITS_W-1:0] glyph_bits;
		logic [LINE_W-1:0]  pixel_line;
		logic               line_start;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

`default_nettype wire

[rtl/tmsr_ifs.sv]
`default_nettype none

interface tmsr_in_if;
	logic                           valid;
	logic                           ready;
	logic [tmsr_pkg::MODE_W-1:0]    mode;
	logic [tmsr_pkg::ROW_W-1:0]     text_row;
	logic [tmsr_pkg::COL_W-1:0]     text_col;
	logic [tmsr_pkg::CODE_W-1:0]    char_code;
	logic [tmsr_pkg::GIDX_W-1:0]    glyph_index;
	logic [tmsr_pkg::GROW_W-1:0]    glyph_row;
	logic [tmsr_pkg::GBITS_W-1:0]   glyph_bits;
	logic [tmsr_pkg::LINE_W-1:0]    pixel_line;
	logic                           line_start;

	modport source (output valid, mode, text_row, text_col, char_code, glyph_index,
		glyph_row, glyph_bits, pixel_line, line_start, input ready);
	modport sink (input valid, mode, text_row, text_col, char_code, glyph_index,
		glyph_row, glyph_bits, pixel_line, line_start, output ready);
endinterface

interface tmsr_out_if;
	logic                          valid;
	logic                          ready;
	logic [tmsr_pkg::WORD_W-1:0]   pixel_word;
	logic                          line_end;

	modport source (output valid, pixel_word, line_end, input ready);
	modport sink (input valid, pixel_word, line_end, output ready);
endinterface

`default_nettype wire

[rtl/tmsr_front.sv]
`default_nettype none

module tmsr_front #(
	parameter int TEXT_COLS     = 128,
	parameter int TEXT_ROWS     = 64,
	parameter int GLYPHS        = 256,
	parameter int MAX_CELL_SIZE = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	tmsr_in_if.sink           item,
	output tmsr_pkg::q_head_t q_head,
	input  logic              q_pop
);
	import tmsr_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push;
	cmd_t       cmd_in;

	// Out-of-range writes and the unused mode are dropped here.
	always_comb begin
		unique case (item.mode)
			MODE_CELL:   keep = (int'(item.text_row) < TEXT_ROWS) &&
				(int'(item.text_col) < TEXT_COLS);
			MODE_GLYPH:  keep = (int'(item.glyph_index) < GLYPHS) &&
				(int'(item.glyph_row) < MAX_CELL_SIZE);
			MODE_RENDER: keep = 1'b1;
			default:     keep = 1'b0;
		endcase
	end

	assign item.ready = (cnt_q != 2'd2);
	assign push       = item.valid && item.ready && keep;

	assign cmd_in.op          = item.mode;
	assign cmd_in.text_row    = item.text_row;
	assign cmd_in.text_col    = item.text_col;
	assign cmd_in.char_code   = item.char_code;
	assign cmd_in.glyph_index = item.glyph_index;
	assign cmd_in.glyph_row   = item.glyph_row;
	assign cmd_in.glyph_bits  = item.glyph_bits;
	assign cmd_in.pixel_line  = item.pixel_line;
	assign cmd_in.line_start  = item.line_start;

	assign q_head.valid = (cnt_q != 2'd0);
	assign q_head.cmd   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= cmd_in;
	end

endmodule

`default_nettype wire

[rtl/tmsr_div.sv]
`default_nettype none

module tmsr_div #(
	parameter int DW = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tmsr_pkg::LINE_W-1:0]   line,
	input  logic [DW-1:0]                 height,
	output logic                          done,
	output logic [tmsr_pkg::LINE_W-1:0]   quot,
	output logic [DW-1:0]                 rem
);
	import tmsr_pkg::*;

	localparam int CNW = $clog2(LINE_W);

	logic              busy_q;
	logic              done_q;
	logic [CNW-1:0]    cnt_q;
	logic [LINE_W-1:0] n_q;
	logic [DW-1:0]     r_q;
	logic [DW-1:0]     d_q;
	logic [DW:0]       trial;
	logic [DW:0]       diff;
	logic              ge;

	// Restoring division, one quotient bit per cycle.
	assign trial = {r_q, n_q[LINE_W-1]};
	assign ge    = (trial >= {1'b0, d_q});
	assign diff  = trial - {1'b0, d_q};

	assign done = done_q;
	assign quot = n_q;
	assign rem  = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNW'(1);
				if (cnt_q == CNW'(LINE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= line;
			r_q <= '0;
			d_q <= height;
		end else if (busy_q) begin
			r_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			n_q <= {n_q[LINE_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

[rtl/tmsr_back.sv]
`default_nettype none

module tmsr_back #(
	parameter int TEXT_COLS     = 128,
	parameter int TEXT_ROWS     = 64,
	parameter int GLYPHS        = 256,
	parameter int MAX_CELL_SIZE = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tmsr_pkg::cfg_t                        cfg,
	input  tmsr_pkg::q_head_t                     q_head,
	output logic                                  q_pop,
	output logic                                  div_start,
	output logic [tmsr_pkg::LINE_W-1:0]           div_line,
	output logic [$clog2(MAX_CELL_SIZE+1)-1:0]    div_height,
	input  logic                                  div_done,
	input  logic [tmsr_pkg::LINE_W-1:0]           div_quot,
	input  logic [$clog2(MAX_CELL_SIZE+1)-1:0]    div_rem,
	tmsr_out_if.source                            result
);
	import tmsr_pkg::*;

	localparam int SW  = $clog2(MAX_CELL_SIZE + 1);
	localparam int CIW = $clog2(MAX_CELL_SIZE);
	localparam int TA  = $clog2(TEXT_ROWS * TEXT_COLS);
	localparam int GA  = $clog2(GLYPHS * MAX_CELL_SIZE);
	localparam int CCW = $clog2(TEXT_COLS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_TREAD = 3'd2;
	localparam logic [2:0] S_TWAIT = 3'd3;
	localparam logic [2:0] S_PIX   = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [7:0]  text_mem  [TEXT_ROWS * TEXT_COLS];
	logic [15:0] glyph_mem [GLYPHS * MAX_CELL_SIZE];

	logic [2:0]        state_q, state_d;
	logic [LINE_W-1:0] cell_row_q;
	logic [CIW-1:0]    rig_q;
	logic [CCW-1:0]    cell_col_q;
	logic [CIW-1:0]    col_q;
	logic [PCNT_W-1:0] pc_q;
	logic [1:0]        pix_idx_q;
	logic [WORD_W-1:0] word_q;
	logic              in_range_q;
	logic              blank_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_end_q;
	logic [7:0]        t_rd_q;
	logic [15:0]       g_rd_q;

	logic              t_we, g_we, t_re, g_re;
	logic [TA-1:0]     t_waddr, t_raddr;
	logic [GA-1:0]     g_waddr, g_raddr;
	logic [SW-1:0]     eff_w, eff_h;
	logic [PCNT_W-1:0] hr_up, eff_hres, pc_next;
	logic              t_in;
	logic [7:0]        code_raw, code_sel, gidx;
	logic              glyph_ok;
	logic [15:0]       bits;
	logic              pix_bit;
	logic [7:0]        pix_byte;
	logic [CIW:0]      col_inc;
	logic              wrap;
	logic              emit_ok;

	function automatic logic code_ok(input logic [7:0] code, input logic [7:0] first,
		input logic [8:0] count);
		logic [7:0] d;
		d = code - first;
		return (code >= first) && ({1'b0, d} < count);
	endfunction

	always_comb begin
		if (cfg.char_width > MAX_CELL_SIZE)   eff_w = SW'(MAX_CELL_SIZE);
		else if (cfg.char_width < 5'd4)       eff_w = SW'(4);
		else                                  eff_w = SW'(cfg.char_width);
		if (cfg.char_height > MAX_CELL_SIZE)  eff_h = SW'(MAX_CELL_SIZE);
		else if (cfg.char_height == 5'd0)     eff_h = SW'(1);
		else                                  eff_h = SW'(cfg.char_height);
	end

	assign hr_up    = ({1'b0, cfg.h_res} + PCNT_W'(3)) & ~PCNT_W'(3);
	assign eff_hres = (hr_up < PCNT_W'(4)) ? PCNT_W'(4) : hr_up;
	assign pc_next  = (pc_q < COUNT_CAP) ? pc_q + PCNT_W'(4) : pc_q;

	assign t_in    = (int'(cell_row_q) < TEXT_ROWS) && (int'(cell_col_q) < TEXT_COLS);
	assign t_raddr = TA'(int'(cell_row_q) * TEXT_COLS + int'(cell_col_q));
	assign t_waddr = TA'(int'(q_head.cmd.text_row) * TEXT_COLS + int'(q_head.cmd.text_col));
	assign g_waddr = GA'(int'(q_head.cmd.glyph_index) * MAX_CELL_SIZE +
		int'(q_head.cmd.glyph_row));

	assign code_raw = in_range_q ? t_rd_q : SPACE_CODE;
	assign code_sel = code_ok(code_raw, cfg.first_char, cfg.glyph_count) ? code_raw :
		SPACE_CODE;
	assign gidx     = code_sel - cfg.first_char;
	assign glyph_ok = code_ok(code_sel, cfg.first_char, cfg.glyph_count) &&
		(int'(gidx) < GLYPHS);
	assign g_raddr  = GA'(int'(gidx) * MAX_CELL_SIZE + int'(rig_q));

	assign bits     = blank_q ? 16'h0000 : g_rd_q;
	assign pix_bit  = (int'(col_q) < 16) ? bits[4'(col_q)] : 1'b0;
	assign pix_byte = cfg.sync_bits | (pix_bit ? cfg.fg_color : cfg.bg_color);
	assign col_inc  = (CIW+1)'(col_q) + (CIW+1)'(1);
	assign wrap     = (col_inc >= eff_w);
	assign emit_ok  = !out_valid_q || result.ready;

	assign div_line   = q_head.cmd.pixel_line;
	assign div_height = eff_h;

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		t_we      = 1'b0;
		g_we      = 1'b0;
		t_re      = 1'b0;
		g_re      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_head.valid) begin
					q_pop = 1'b1;
					unique case (q_head.cmd.op)
						MODE_CELL:  t_we = 1'b1;
						MODE_GLYPH: g_we = 1'b1;
						default: begin
							if (q_head.cmd.line_start) begin
								div_start = 1'b1;
								state_d   = S_DIV;
							end else begin
								state_d = S_TREAD;
							end
						end
					endcase
				end
			end
			S_DIV: begin
				if (div_done) state_d = S_TREAD;
			end
			S_TREAD: begin
				t_re    = t_in;
				state_d = S_TWAIT;
			end
			S_TWAIT: begin
				g_re    = glyph_ok;
				state_d = S_PIX;
			end
			S_PIX: begin
				if (pix_idx_q == 2'd3) state_d = S_EMIT;
				else if (wrap)         state_d = S_TREAD;
			end
			S_EMIT: begin
				if (emit_ok) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (t_we) text_mem[t_waddr] <= q_head.cmd.char_code;
		if (t_re) t_rd_q <= text_mem[t_raddr];
	end

	always_ff @(posedge clk) begin
		if (g_we) glyph_mem[g_waddr] <= q_head.cmd.glyph_bits;
		if (g_re) g_rd_q <= glyph_mem[g_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cell_row_q  <= '0;
			rig_q       <= '0;
			cell_col_q  <= '0;
			col_q       <= '0;
			pc_q        <= '0;
			pix_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && result.ready) out_valid_q <= 1'b0;
			if (state_q == S_DIV && div_done) begin
				cell_row_q <= div_quot;
				rig_q      <= CIW'(div_rem);
				cell_col_q <= '0;
				col_q      <= '0;
				pc_q       <= '0;
			end
			if (state_q == S_PIX) begin
				pix_idx_q <= pix_idx_q + 2'd1;
				if (wrap) begin
					col_q <= '0;
					if (cell_col_q != CCW'(TEXT_COLS)) cell_col_q <= cell_col_q + CCW'(1);
				end else begin
					col_q <= col_inc[CIW-1:0];
				end
			end
			if (state_q == S_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
				pc_q        <= pc_next;
			end
		end
	end

	// Pixels 0..3 land in bytes 2, 3, 0, 1.
	always_ff @(posedge clk) begin
		if (state_q == S_TREAD) in_range_q <= t_in;
		if (state_q == S_TWAIT) blank_q <= !glyph_ok;
		if (state_q == S_PIX) begin
			unique case (pix_idx_q)
				2'd0: word_q[23:16] <= pix_byte;
				2'd1: word_q[31:24] <= pix_byte;
				2'd2: word_q[7:0]   <= pix_byte;
				2'd3: word_q[15:8]  <= pix_byte;
			endcase
		end
		if (state_q == S_EMIT && emit_ok) begin
			out_word_q <= word_q;
			out_end_q  <= (pc_next >= eff_hres);
		end
	end

	assign result.valid      = out_valid_q;
	assign result.pixel_word = out_word_q;
	assign result.line_end   = out_end_q;

endmodule

`default_nettype wire

[rtl/text_mode_scanline_renderer_unit.sv]
`default_nettype none

// Channel  Direction  Handshake    Payload
// item     in         valid/ready  mode, text_row, text_col, char_code, glyph_index,
//                                  glyph_row, glyph_bits, pixel_line, line_start
// result   out        valid/ready  pixel_word, line_end
// cfg      in         cfg_we       cfg_index, cfg_data
//
// A cell or glyph write item is handled in the back end's idle state; a render item
// does one text read and one glyph read per cell that its four pixels span, then
// one pixel per cycle.
// A render item with line_start first runs the row divider, which produces one
// quotient bit per cycle.
// A two-entry queue keeps taking items, until it is full, while the back end works or
// the result register waits; reset empties it and clears the counters, not the stores.

module text_mode_scanline_renderer_unit #(
	parameter int TEXT_COLS     = 128,
	parameter int TEXT_ROWS     = 64,
	parameter int GLYPHS        = 256,
	parameter int MAX_CELL_SIZE = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tmsr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tmsr_pkg::CFG_DATA_W-1:0]   cfg_data,
	tmsr_in_if.sink                           item,
	tmsr_out_if.source                        result
);
	import tmsr_pkg::*;

	localparam int SW = $clog2(MAX_CELL_SIZE + 1);

	cfg_t              cfg_q;
	q_head_t           q_head;
	logic              q_pop;
	logic              div_start;
	logic              div_done;
	logic [LINE_W-1:0] div_line;
	logic [LINE_W-1:0] div_quot;
	logic [SW-1:0]     div_height;
	logic [SW-1:0]     div_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.char_width  <= 5'd8;
			cfg_q.char_height <= 5'd8;
			cfg_q.first_char  <= 8'd32;
			cfg_q.glyph_count <= 9'd96;
			cfg_q.fg_color    <= 8'd255;
			cfg_q.bg_color    <= 8'd0;
			cfg_q.sync_bits   <= 8'd0;
			cfg_q.h_res       <= 11'd640;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHAR_WIDTH:  cfg_q.char_width  <= cfg_data[4:0];
				REG_CHAR_HEIGHT: cfg_q.char_height <= cfg_data[4:0];
				REG_FIRST_CHAR:  cfg_q.first_char  <= cfg_data[7:0];
				REG_GLYPH_COUNT: cfg_q.glyph_count <= cfg_data[8:0];
				REG_FG_COLOR:    cfg_q.fg_color    <= cfg_data[7:0];
				REG_BG_COLOR:    cfg_q.bg_color    <= cfg_data[7:0];
				REG_SYNC_BITS:   cfg_q.sync_bits   <= cfg_data[7:0];
				REG_H_RES:       cfg_q.h_res       <= cfg_data[10:0];
			endcase
		end
	end

	tmsr_front #(
		.TEXT_COLS(TEXT_COLS),
		.TEXT_ROWS(TEXT_ROWS),
		.GLYPHS(GLYPHS),
		.MAX_CELL_SIZE(MAX_CELL_SIZE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.q_head(q_head),
		.q_pop(q_pop)
	);

	tmsr_div #(
		.DW(SW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.line(div_line),
		.height(div_height),
		.done(div_done),
		.quot(div_quot),
		.rem(div_rem)
	);

	tmsr_back #(
		.TEXT_COLS(TEXT_COLS),
		.TEXT_ROWS(TEXT_ROWS),
		.GLYPHS(GLYPHS),
		.MAX_CELL_SIZE(MAX_CELL_SIZE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_head(q_head),
		.q_pop(q_pop),
		.div_start(div_start),
		.div_line(div_line),
		.div_height(div_height),
		.div_done(div_done),
		.div_quot(div_quot),
		.div_rem(div_rem),
		.result(result)
	);

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_head.valid)
		else $error("queue popped while empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.cmd.op == MODE_RENDER && q_head.cmd.line_start) |-> div_start)
		else $error("line start item did not start the row divider");

	assert property (@(posedge clk) disable iff (!arst_n) div_start |=> !div_done)
		else $error("row divider finished too early");

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import tmsr_pkg::*;

	localparam int TEXT_COLS     = 128;
	localparam int TEXT_ROWS     = 64;
	localparam int GLYPHS        = 256;
	localparam int MAX_CELL_SIZE = 16;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
	localparam int IDLE_PCT      = 28;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS   = 10;
	localparam int HOLD_CYCLES   = 300;

	typedef struct {
		logic [WORD_W-1:0] pixel_word;
		logic              line_end;
	} scan_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tmsr_in_if  item_if();
	tmsr_out_if result_if();

	text_mode_scanline_renderer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_if),
		.result    (result_if)
	);

	cmd_t       pending_cmds[$];
	scan_word_t expected_words[$];
	logic       cmd_taken;
	logic       steady;
	int         hold_req;
	int         hold_left;
	int         mismatch_count;

	// Shadow of the block: stores, scan position and registers.
	logic [7:0]  chars [TEXT_ROWS*TEXT_COLS];
	logic [15:0] glyph_rows [GLYPHS*MAX_CELL_SIZE];
	int          cur_row;
	int          glyph_line;
	int          cur_col;
	int          sub_col;
	int          pix_done;
	cfg_t        cfg_model;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int cell_w();
		int w;
		w = cfg_model.char_width;
		if (w < 4) w = 4;
		if (w > MAX_CELL_SIZE) w = MAX_CELL_SIZE;
		return w;
	endfunction

	function automatic int cell_h();
		int h;
		h = cfg_model.char_height;
		if (h < 1) h = 1;
		if (h > MAX_CELL_SIZE) h = MAX_CELL_SIZE;
		return h;
	endfunction

	function automatic int line_pixels();
		int p;
		p = (int'(cfg_model.h_res) + 3) & ~3;
		if (p < 4) p = 4;
		return p;
	endfunction

	function automatic bit code_in_font(int code);
		int first;
		int count;
		first = cfg_model.first_char;
		count = cfg_model.glyph_count;
		return code >= first && (code - first) < count;
	endfunction

	function automatic logic [15:0] cur_glyph_bits();
		int code;
		int g;
		code = SPACE_CODE;
		if (cur_row < TEXT_ROWS && cur_col < TEXT_COLS)
			code = chars[cur_row*TEXT_COLS + cur_col];
		if (!code_in_font(code)) code = SPACE_CODE;
		if (!code_in_font(code)) return '0;
		g = code - int'(cfg_model.first_char);
		if (g >= GLYPHS || glyph_line >= MAX_CELL_SIZE) return '0;
		return glyph_rows[g*MAX_CELL_SIZE + glyph_line];
	endfunction

	function automatic logic [7:0] next_pixel_byte();
		logic [15:0] bits;
		logic        lit;
		bits = cur_glyph_bits();
		lit = (sub_col < 16) ? bits[sub_col] : 1'b0;
		sub_col++;
		if (sub_col >= cell_w()) begin
			sub_col = 0;
			if (cur_col < 'hFFFF) cur_col++;
		end
		return cfg_model.sync_bits | (lit ? cfg_model.fg_color : cfg_model.bg_color);
	endfunction

	function automatic void scan_step(cmd_t c);
		logic [7:0] px [4];
		scan_word_t w;
		int         i;
		case (c.op)
		MODE_CELL: chars[c.text_row*TEXT_COLS + c.text_col] = c.char_code;
		MODE_GLYPH: glyph_rows[c.glyph_index*MAX_CELL_SIZE + c.glyph_row] = c.glyph_bits;
		MODE_RENDER: begin
			if (c.line_start) begin
				cur_row = int'(c.pixel_line) / cell_h();
				glyph_line = int'(c.pixel_line) % cell_h();
				cur_col = 0;
				sub_col = 0;
				pix_done = 0;
			end
			for (i = 0; i < 4; i++)
				px[i] = next_pixel_byte();
			w.pixel_word = {px[1], px[0], px[3], px[2]};
			if (pix_done < COUNT_CAP) pix_done += 4;
			w.line_end = (pix_done >= line_pixels());
			expected_words.push_back(w);
		end
		default: ;
		endcase
	endfunction

	function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
	endfunction

	function automatic cmd_t random_cmd(logic [MODE_W-1:0] op);
		cmd_t       c;
		logic [63:0] r;
		r = {$urandom, $urandom};
		c = r[$bits(cmd_t)-1:0];
		c.op = op;
		return c;
	endfunction

	function automatic void queue_cell(int row, int col, int code);
		cmd_t c;
		c = random_cmd(MODE_CELL);
		c.text_row = row;
		c.text_col = col;
		c.char_code = code;
		pending_cmds.push_back(c);
	endfunction

	function automatic void queue_glyph(int idx, int row, int bits);
		cmd_t c;
		c = random_cmd(MODE_GLYPH);
		c.glyph_index = idx;
		c.glyph_row = row;
		c.glyph_bits = bits;
		pending_cmds.push_back(c);
	endfunction

	function automatic void queue_render(int line, logic start);
		cmd_t c;
		c = random_cmd(MODE_RENDER);
		c.pixel_line = line;
		c.line_start = start;
		pending_cmds.push_back(c);
	endfunction

	function automatic void queue_line(int line, int n_words);
		int i;
		queue_render(line, 1'b1);
		for (i = 1; i < n_words; i++)
			queue_render($urandom_range(0, 1023), 1'b0);
	endfunction

	function automatic int font_code();
		int first;
		int count;
		first = cfg_model.first_char;
		count = cfg_model.glyph_count;
		if (count > 0 && $urandom_range(0, 99) < 60) begin
			if (first + count > 256) count = 256 - first;
			return first + $urandom_range(0, count - 1);
		end
		return $urandom_range(0, 255);
	endfunction

	function automatic int pick_line();
		int span;
		span = TEXT_ROWS * cell_h();
		if (span > 1024) span = 1024;
		if ($urandom_range(0, 99) < 75) return $urandom_range(0, span - 1);
		return $urandom_range(0, 1023);
	endfunction

	// Mostly well-formed line scans with random content, mixed with store
	// writes, ignored items and scans that resume without a line start.
	function automatic void random_phase(int n_items);
		int done;
		int pick;
		int wpl;
		int k;
		cmd_t c;
		done = 0;
		while (done < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				queue_cell($urandom_range(0, TEXT_ROWS - 1), $urandom_range(0, TEXT_COLS - 1),
					font_code());
				done++;
			end else if (pick < 27) begin
				queue_glyph($urandom_range(0, GLYPHS - 1), $urandom_range(0, MAX_CELL_SIZE - 1),
					$urandom_range(0, 65535));
				done++;
			end else if (pick < 30) begin
				c = random_cmd(MODE_NONE);
				pending_cmds.push_back(c);
			end else begin
				wpl = line_pixels() / 4;
				k = $urandom_range(0, (wpl < 30) ? wpl + 2 : 30);
				if (pick < 36)
					queue_render($urandom_range(0, 1023), 1'b0);
				else
					queue_render(pick_line(), 1'b1);
				repeat (k) queue_render($urandom_range(0, 1023), 1'b0);
				done += k + 1;
			end
		end
	endfunction

	task automatic wait_for_drain();
		while (pending_cmds.size() != 0 || expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		case (idx)
		REG_CHAR_WIDTH:  cfg_model.char_width = val[4:0];
		REG_CHAR_HEIGHT: cfg_model.char_height = val[4:0];
		REG_FIRST_CHAR:  cfg_model.first_char = val[7:0];
		REG_GLYPH_COUNT: cfg_model.glyph_count = val[8:0];
		REG_FG_COLOR:    cfg_model.fg_color = val[7:0];
		REG_BG_COLOR:    cfg_model.bg_color = val[7:0];
		REG_SYNC_BITS:   cfg_model.sync_bits = val[7:0];
		REG_H_RES:       cfg_model.h_res = val[10:0];
		default: ;
		endcase
	endtask

	task automatic set_config(int w, int h, int first, int count, int fg, int bg, int sync,
		int hres);
		wait_for_drain();
		write_reg(REG_CHAR_WIDTH, w);
		write_reg(REG_CHAR_HEIGHT, h);
		write_reg(REG_FIRST_CHAR, first);
		write_reg(REG_GLYPH_COUNT, count);
		write_reg(REG_FG_COLOR, fg);
		write_reg(REG_BG_COLOR, bg);
		write_reg(REG_SYNC_BITS, sync);
		write_reg(REG_H_RES, hres);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && item_if.valid && item_if.ready) begin
			scan_step(pending_cmds.pop_front());
			cmd_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_if.valid || cmd_taken) begin
				if (pending_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					item_if.valid <= 1'b1;
					item_if.mode <= pending_cmds[0].op;
					item_if.text_row <= pending_cmds[0].text_row;
					item_if.text_col <= pending_cmds[0].text_col;
					item_if.char_code <= pending_cmds[0].char_code;
					item_if.glyph_index <= pending_cmds[0].glyph_index;
					item_if.glyph_row <= pending_cmds[0].glyph_row;
					item_if.glyph_bits <= pending_cmds[0].glyph_bits;
					item_if.pixel_line <= pending_cmds[0].pixel_line;
					item_if.line_start <= pending_cmds[0].line_start;
				end else begin
					item_if.valid <= 1'b0;
				end
			end
			cmd_taken = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			result_if.ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		scan_word_t w;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_words.size() == 0) begin
				note_mismatch("unexpected item", 'x, result_if.pixel_word);
			end else begin
				w = expected_words.pop_front();
				if (result_if.pixel_word !== w.pixel_word)
					note_mismatch("pixel_word", w.pixel_word, result_if.pixel_word);
				if (result_if.line_end !== w.line_end)
					note_mismatch("line_end", w.line_end, result_if.line_end);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int r;
		int col;
		cmd_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CHAR_WIDTH;
		cfg_data = '0;
		item_if.valid = 1'b0;
		item_if.mode = MODE_CELL;
		item_if.text_row = '0;
		item_if.text_col = '0;
		item_if.char_code = '0;
		item_if.glyph_index = '0;
		item_if.glyph_row = '0;
		item_if.glyph_bits = '0;
		item_if.pixel_line = '0;
		item_if.line_start = 1'b0;
		result_if.ready = 1'b0;
		cmd_taken = 1'b0;
		steady = 1'b1;
		hold_req = 0;
		hold_left = 0;
		mismatch_count = 0;
		cur_row = 0;
		glyph_line = 0;
		cur_col = 0;
		sub_col = 0;
		pix_done = 0;
		cfg_model.char_width = 5'd8;
		cfg_model.char_height = 5'd8;
		cfg_model.first_char = 8'd32;
		cfg_model.glyph_count = 9'd96;
		cfg_model.fg_color = 8'd255;
		cfg_model.bg_color = 8'd0;
		cfg_model.sync_bits = 8'd0;
		cfg_model.h_res = 11'd640;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill both stores so that no scan ever reads an unwritten entry.
		for (r = 0; r < TEXT_ROWS; r++)
			for (col = 0; col < TEXT_COLS; col++)
				queue_cell(r, col, $urandom_range(0, 255));
		for (r = 0; r < GLYPHS; r++)
			for (col = 0; col < MAX_CELL_SIZE; col++)
				queue_glyph(r, col, $urandom_range(0, 65535));

		set_config(5, 3, 32, 96, 'hF0, 'h05, 'hC0, 10);
		steady = 1'b0;
		queue_render(1023, 1'b0);
		c = '1;
		c.op = MODE_NONE;
		pending_cmds.push_back(c);
		queue_cell(0, 0, 'hFF);
		queue_cell(TEXT_ROWS - 1, TEXT_COLS - 1, 'h00);
		queue_cell(0, 1, 'h7F);
		queue_cell(0, 2, SPACE_CODE);
		queue_cell(TEXT_ROWS - 1, 0, 'h7F);
		queue_glyph(GLYPHS - 1, MAX_CELL_SIZE - 1, 'hFFFF);
		queue_glyph(0, 0, 'h0000);
		queue_glyph('h5F, 0, 'hAAAA);
		queue_glyph('h5F, 2, 'h5555);
		queue_render(0, 1'b1);
		repeat (5) queue_render(1023, 1'b0);
		queue_render(1023, 1'b1);
		queue_render(0, 1'b0);
		queue_render(191, 1'b1);
		queue_render(0, 1'b0);
		random_phase(40);

		set_config(4, 1, 0, 511, 'h3C, 'hA5, 'h00, 1024);
		queue_line(pick_line(), 258);
		random_phase(60);

		set_config(16, 16, 200, 56, 'h81, 'h7E, 'h18, 36);
		steady = 1'b1;
		random_phase(70);

		set_config(31, 0, 255, 0, 'hFF, 'hFF, 'hFF, 0);
		steady = 1'b0;
		random_phase(40);

		set_config(0, 31, 33, 2, 'h00, 'h00, 'h80, 2047);
		queue_line(pick_line(), 515);
		random_phase(30);

		// The scan resumes under new settings, then the receiver holds off
		// while the queue keeps offering items.
		set_config(7, 5, 16, 300, 'h5A, 'hC3, 'h24, 99);
		repeat (3) queue_render($urandom_range(0, 1023), 1'b0);
		hold_req = HOLD_CYCLES;
		random_phase(80);

		set_config(12, 11, 64, 64, 'h0F, 'hF0, 'h01, 252);
		random_phase(70);

		set_config(9, 16, 32, 96, 'hFF, 'h00, 'h40, 640);
		random_phase(60);

		wait_for_drain();
		if (mismatch_count == 0 && expected_words.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
